[src/bdq_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the bounded deque with delete by value.
// No dependencies; imported by bdq_cell and bounded_deque_with_value_delete.
package bdq_pkg;

    localparam int unsigned DataW   = 32;
    localparam int unsigned CmdW    = 3;
    localparam int unsigned StatusW = 2;
    localparam int unsigned CountW  = 5;

    // Command codes
    typedef enum logic [CmdW-1:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_REM_FRONT = 3'd2,
        CMD_REM_BACK  = 3'd3,
        CMD_REM_VALUE = 3'd4
    } cmd_t;

    // Result status codes
    typedef enum logic [StatusW-1:0] {
        STS_DONE     = 2'd0,
        STS_EMPTY    = 2'd1,
        STS_FULL     = 2'd2,
        STS_NOTFOUND = 2'd3
    } status_t;

    // Sequencer states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // Per-cycle command to every cell, already gated by full/empty checks
    typedef struct packed {
        logic ins_front;
        logic ins_back;
        logic rem_front;
        logic rem_value;
    } cell_ctrl_t;

endpackage

[src/bounded_deque_with_value_delete.sv]
`timescale 1ns / 1ps
// Top level of the bounded deque with delete by value: sequencer, entry count
// and a chain of bdq_cell storage cells. Depends on bdq_pkg and bdq_cell.
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  cmd     | cmd_valid, cmd_stall, command, value  | in
//  rsp     | rsp_valid, rsp_stall, status, count_after | out
//
// Each command is first registered from the transfer, then executed: all cells
// compare against the key, the backmost match is found through the cell chain
// and the cells shift or load at once.
// The command channel is stalled during execute; the result sits in
// an output register, so a new command is taken while a result still waits.
// Execute holds while the previous result has not been taken.
// Reset empties the store at once; cell contents are not cleared.
module bounded_deque_with_value_delete
    import bdq_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    output logic                       cmd_stall,
    input  logic        [CmdW-1:0]     command,
    input  logic signed [DataW-1:0]    value,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output logic        [StatusW-1:0]  status,
    output logic        [CountW-1:0]   count_after
);

    localparam int unsigned CW = $clog2(DEPTH + 1);

    state_t                  state_reg;
    state_t                  state_next;
    logic        [CmdW-1:0]  cmd_reg;
    logic signed [DataW-1:0] key_reg;
    logic        [CW-1:0]    count_reg;
    logic        [CW-1:0]    count_next;
    logic                    rsp_valid_reg;
    logic                    rsp_valid_next;
    status_t                 status_reg;
    status_t                 status_next;
    logic        [CountW-1:0] count_out_reg;

    logic                    fire;
    logic                    accept;
    logic                    full;
    logic                    empty;
    logic                    found;
    cell_ctrl_t              ctrl;

    logic signed [DataW-1:0] cell_val [DEPTH];
    logic                    above    [DEPTH+1];

    assign accept = cmd_valid && !cmd_stall;
    assign full   = count_reg == CW'(DEPTH);
    assign empty  = count_reg == '0;
    assign found  = above[0];

    // Sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer: outputs
    always_comb
    begin
        cmd_stall = 1'b1;
        fire      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd_stall = 1'b0;
            end
            ST_EXEC:
            begin
                fire = !rsp_valid_reg || !rsp_stall;
            end
            default:
            begin
                cmd_stall = 1'b1;
            end
        endcase
    end

    // Decode the command into cell controls, status and new count
    always_comb
    begin
        ctrl        = '0;
        status_next = STS_DONE;
        count_next  = count_reg;
        case (cmd_reg)
            CMD_INS_FRONT:
            begin
                if (full)
                begin
                    status_next = STS_FULL;
                end
                else
                begin
                    ctrl.ins_front = fire;
                    count_next     = count_reg + CW'(1);
                end
            end
            CMD_INS_BACK:
            begin
                if (full)
                begin
                    status_next = STS_FULL;
                end
                else
                begin
                    ctrl.ins_back = fire;
                    count_next    = count_reg + CW'(1);
                end
            end
            CMD_REM_FRONT:
            begin
                if (empty)
                begin
                    status_next = STS_EMPTY;
                end
                else
                begin
                    ctrl.rem_front = fire;
                    count_next     = count_reg - CW'(1);
                end
            end
            CMD_REM_BACK:
            begin
                if (empty)
                begin
                    status_next = STS_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            CMD_REM_VALUE:
            begin
                if (empty)
                begin
                    status_next = STS_EMPTY;
                end
                else if (!found)
                begin
                    status_next = STS_NOTFOUND;
                end
                else
                begin
                    ctrl.rem_value = fire;
                    count_next     = count_reg - CW'(1);
                end
            end
            default:
            begin
                status_next = STS_DONE;
            end
        endcase
    end

    // Build the cell chain; the match flag ripples from back to front
    assign above[DEPTH] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DataW-1:0] left_v;
        logic signed [DataW-1:0] right_v;

        if (i == 0)
        begin : g_first
            assign left_v = key_reg;
        end
        else
        begin : g_mid_l
            assign left_v = cell_val[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_v = key_reg;
        end
        else
        begin : g_mid_r
            assign right_v = cell_val[i+1];
        end

        bdq_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .count     (count_reg),
            .key       (key_reg),
            .left_val  (left_v),
            .right_val (right_v),
            .above_in  (above[i+1]),
            .found     (found),
            .val       (cell_val[i]),
            .above_out (above[i])
        );
    end

    // Result valid: set on execute, drop once the result transfers
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (fire)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Hold the command and the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= command;
            key_reg <= value;
        end
        if (fire)
        begin
            status_reg    <= status_next;
            count_out_reg <= CountW'(count_next);
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign count_after = count_out_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_rsp_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_EXEC))
        else $error("result raised without an execute cycle");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && status_reg == STS_FULL) |-> count_out_reg == CountW'(DEPTH))
        else $error("full status with count below depth");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && status_reg == STS_EMPTY) |-> count_out_reg == '0)
        else $error("empty status with nonzero count");

endmodule

[src/bdq_cell.sv]
`timescale 1ns / 1ps
// One storage cell of the deque chain: holds a value, compares it to the key
// and moves data to or from its neighbors. Depends on bdq_pkg.
module bdq_cell
    import bdq_pkg::*;
#(
    parameter int unsigned IDX = 0,
    parameter int unsigned CW  = 5
) (
    input  logic                     clk,
    input  cell_ctrl_t               ctrl,
    input  logic        [CW-1:0]     count,
    input  logic signed [DataW-1:0]  key,
    input  logic signed [DataW-1:0]  left_val,
    input  logic signed [DataW-1:0]  right_val,
    input  logic                     above_in,
    input  logic                     found,
    output logic signed [DataW-1:0]  val,
    output logic                     above_out
);

    logic signed [DataW-1:0] val_reg;
    logic signed [DataW-1:0] val_next;
    logic                    in_range;
    logic                    match;
    logic                    at_tail;

    // Compare against the key only inside the occupied region
    assign in_range  = CW'(IDX) < count;
    assign at_tail   = CW'(IDX) == count;
    assign match     = in_range && (val_reg == key);
    // Pass "a match exists at this index or above" toward the front
    assign above_out = above_in | match;

    // Select the next value: shift in from either side or load the key
    always_comb
    begin
        val_next = val_reg;
        if (ctrl.ins_front)
        begin
            val_next = left_val;
        end
        else if (ctrl.ins_back && at_tail)
        begin
            val_next = key;
        end
        else if (ctrl.rem_front)
        begin
            val_next = right_val;
        end
        else if (ctrl.rem_value && found && !above_in)
        begin
            // at or behind the backmost match: close the gap
            val_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule
